@@ src/dtb_pkg.sv @@
// ----------------------------------------------------------------------------
// dtb_pkg: shared types and constants of the deadline timer bank
// Item structs, command and result codes, and slot sizing.
// ----------------------------------------------------------------------------
package dtb_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int MAX_REP   = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
    localparam int CNT_W     = $clog2(MAX_REP + 1);

    localparam logic [31:0] TPS_RESET = 32'd1000000;

    localparam logic [2:0] ACT_START_S = 3'd0;
    localparam logic [2:0] ACT_STOP    = 3'd1;
    localparam logic [2:0] ACT_DELAY   = 3'd2;
    localparam logic [2:0] ACT_REMAIN  = 3'd3;
    localparam logic [2:0] ACT_POLL    = 3'd4;
    localparam logic [2:0] ACT_START_F = 3'd5;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_EXPIRE = 2'd1;
    localparam logic [1:0] KIND_REMAIN = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic [3:0]         timer_id;
        logic signed [31:0] amount;
        logic [63:0]        now;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  slot;
        logic        was_fast;
        logic        status;
        logic [31:0] remaining_seconds;
        logic        last;
    } t_out_item;

endpackage

@@ src/dtb_mul.sv @@
// ----------------------------------------------------------------------------
// dtb_mul: registered 32 x 32 multiplier
// Scales second amounts by the tick rate; the product is registered, so it is ready in the next cycle.
// ----------------------------------------------------------------------------
module dtb_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ src/dtb_div.sv @@
// ----------------------------------------------------------------------------
// dtb_div: iterative 64 / 32 unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dtb_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [63:0] r_q;
    logic [32:0] w_trial;
    logic        w_ge;
    logic [32:0] w_diff;

    assign w_trial = {r_rem, r_q[63]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_div  <= i_divisor;
                r_q    <= i_dividend;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
                r_q   <= {r_q[62:0], w_ge};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ src/deadline_timer_bank.sv @@
// ----------------------------------------------------------------------------
// deadline_timer_bank: bank of deadline timer slots with sorted expiry polling
// Start, fast start, delay: decode, add, response. Stop, refused commands: decode,
// response. Remaining query: decode, the bit-serial 64 / 32 divider, response,
// or decode and response when the slot is inactive or due. Poll: a scan of all
// slots per report and per pass, then a pick step. One item at a time.
// Reset clears all slots, the arm counter and the slow check time, and loads
// the default tick rate.
// ----------------------------------------------------------------------------
module deadline_timer_bank (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dtb_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dtb_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_wr_en,
    input  logic [31:0]         i_cfg_wr_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_ADD, S_DIV, S_SCAN, S_PICK, S_RESP
    } t_state;

    t_state                      r_state;
    t_state                      r_after;
    dtb_pkg::t_in_item           r_cmd;
    dtb_pkg::t_out_item          r_res;
    dtb_pkg::t_out_item          r_out_item;
    logic                        r_out_valid;
    logic [31:0]                 r_tps;
    logic [31:0]                 r_arm_cnt;
    logic [63:0]                 r_lsc;
    logic [dtb_pkg::NUM_SLOTS-1:0] r_active;
    logic [dtb_pkg::NUM_SLOTS-1:0] r_fast;
    logic [63:0]                 r_deadline [dtb_pkg::NUM_SLOTS];
    logic [31:0]                 r_order    [dtb_pkg::NUM_SLOTS];

    logic                        r_gate;
    logic                        r_pass_fast;
    logic [dtb_pkg::CNT_W-1:0]   r_n;
    logic [dtb_pkg::IDX_W-1:0]   r_scan_i;
    logic                        r_found;
    logic [dtb_pkg::IDX_W-1:0]   r_best_idx;
    logic [63:0]                 r_best_dl;
    logic [31:0]                 r_best_age;

    logic                        w_out_free;
    logic                        w_id_ok;
    logic [dtb_pkg::IDX_W-1:0]   w_id_idx;
    logic [dtb_pkg::IDX_W-1:0]   w_rd_idx;
    logic [63:0]                 w_rd_dl;
    logic [31:0]                 w_rd_ord;
    logic                        w_rd_act;
    logic                        w_rd_fast;
    logic                        w_active;
    logic [31:0]                 w_tps;
    logic [31:0]                 w_mag;
    logic [63:0]                 w_prod;
    logic [63:0]                 w_base;
    logic [63:0]                 w_addend;
    logic [64:0]                 w_sum;
    logic [63:0]                 w_sat;
    logic                        w_arm_wr;
    logic                        w_gate;
    logic [31:0]                 w_age;
    logic                        w_due;
    logic                        w_better;
    logic                        w_div_start;
    logic                        w_div_done;
    logic [63:0]                 w_quot;

    function automatic dtb_pkg::t_out_item mk_res(
        input logic [1:0]  kind,
        input logic [3:0]  slot,
        input logic        fast,
        input logic        status,
        input logic [31:0] rem,
        input logic        last
    );
        dtb_pkg::t_out_item res;
        res.kind              = kind;
        res.slot              = slot;
        res.was_fast          = fast;
        res.status            = status;
        res.remaining_seconds = rem;
        res.last              = last;
        return res;
    endfunction

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_id_ok    = (int'(r_cmd.timer_id) < dtb_pkg::NUM_SLOTS);
    assign w_id_idx   = dtb_pkg::IDX_W'(r_cmd.timer_id);
    assign w_rd_idx   = (r_state == S_SCAN) ? r_scan_i : w_id_idx;
    assign w_rd_dl    = r_deadline[w_rd_idx];
    assign w_rd_ord   = r_order[w_rd_idx];
    assign w_rd_act   = r_active[w_rd_idx];
    assign w_rd_fast  = r_fast[w_rd_idx];
    assign w_active   = w_id_ok && w_rd_act;

    assign w_tps = (r_tps == 32'd0) ? 32'd1 : r_tps;
    assign w_mag = r_cmd.amount[31] ? 32'd0 : {1'b0, r_cmd.amount[30:0]};

    dtb_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mag),
        .i_b    (w_tps),
        .o_prod (w_prod)
    );

    assign w_base   = (r_cmd.action == dtb_pkg::ACT_DELAY) ? w_rd_dl : r_cmd.now;
    assign w_addend = (r_cmd.action == dtb_pkg::ACT_START_F) ? {32'd0, w_mag} : w_prod;
    assign w_sum    = {1'b0, w_base} + {1'b0, w_addend};
    assign w_sat    = w_sum[64] ? {64{1'b1}} : w_sum[63:0];
    assign w_arm_wr = (r_state == S_ADD);

    assign w_gate = ((r_cmd.now - r_lsc) > {32'd0, w_tps}) || (r_lsc == 64'd0) ||
                    (r_lsc > r_cmd.now);

    assign w_age    = r_arm_cnt - w_rd_ord;
    assign w_due    = w_rd_act && (w_rd_fast == r_pass_fast) && (w_rd_dl <= r_cmd.now);
    assign w_better = !r_found || (w_rd_dl < r_best_dl) ||
                      ((w_rd_dl == r_best_dl) && (w_age > r_best_age));

    assign w_div_start = (r_state == S_DECODE) && (r_cmd.action == dtb_pkg::ACT_REMAIN) &&
                         w_active && (w_rd_dl > r_cmd.now);

    dtb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_rd_dl - r_cmd.now),
        .i_divisor  (w_tps),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_arm_wr) begin
            r_deadline[w_id_idx] <= w_sat;
            r_order[w_id_idx]    <= r_arm_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tps       <= dtb_pkg::TPS_RESET;
            r_arm_cnt   <= '0;
            r_lsc       <= '0;
            r_active    <= '0;
            r_fast      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_tps <= i_cfg_wr_data;
            end
            if (!i_out_stall && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cmd   <= i_in_item;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_after <= S_IDLE;
                    r_state <= S_RESP;
                    unique case (r_cmd.action)
                        dtb_pkg::ACT_START_S, dtb_pkg::ACT_START_F: begin
                            if (w_id_ok) begin
                                r_state <= S_ADD;
                            end else begin
                                r_res <= mk_res(dtb_pkg::KIND_ACK, r_cmd.timer_id,
                                                1'b0, 1'b1, 32'd0, 1'b1);
                            end
                        end
                        dtb_pkg::ACT_DELAY: begin
                            if (w_active) begin
                                r_state <= S_ADD;
                            end else begin
                                r_res <= mk_res(dtb_pkg::KIND_ACK, r_cmd.timer_id,
                                                1'b0, 1'b1, 32'd0, 1'b1);
                            end
                        end
                        dtb_pkg::ACT_STOP: begin
                            if (w_active) begin
                                r_active[w_id_idx] <= 1'b0;
                            end
                            r_res <= mk_res(dtb_pkg::KIND_ACK, r_cmd.timer_id,
                                            1'b0, !w_active, 32'd0, 1'b1);
                        end
                        dtb_pkg::ACT_REMAIN: begin
                            if (w_div_start) begin
                                r_state <= S_DIV;
                            end
                            r_res <= mk_res(dtb_pkg::KIND_REMAIN, r_cmd.timer_id,
                                            1'b0, !w_active, 32'd0, 1'b1);
                        end
                        dtb_pkg::ACT_POLL: begin
                            if (w_gate) begin
                                r_lsc <= r_cmd.now;
                            end
                            r_gate      <= w_gate;
                            r_pass_fast <= 1'b1;
                            r_n         <= '0;
                            r_scan_i    <= '0;
                            r_found     <= 1'b0;
                            r_state     <= S_SCAN;
                        end
                        default: begin
                            r_res <= mk_res(dtb_pkg::KIND_ACK, r_cmd.timer_id,
                                            1'b0, 1'b1, 32'd0, 1'b1);
                        end
                    endcase
                end
                S_ADD: begin
                    r_active[w_id_idx] <= 1'b1;
                    unique case (r_cmd.action)
                        dtb_pkg::ACT_START_F: r_fast[w_id_idx] <= 1'b1;
                        dtb_pkg::ACT_DELAY:   r_fast[w_id_idx] <= w_rd_fast;
                        default:              r_fast[w_id_idx] <= 1'b0;
                    endcase
                    r_arm_cnt <= r_arm_cnt + 32'd1;
                    r_res     <= mk_res(dtb_pkg::KIND_ACK, r_cmd.timer_id,
                                        1'b0, 1'b0, 32'd0, 1'b1);
                    r_after   <= S_IDLE;
                    r_state   <= S_RESP;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res.remaining_seconds <= (w_quot[63:32] != 32'd0) ?
                                                   32'hFFFF_FFFF : w_quot[31:0];
                        r_after <= S_IDLE;
                        r_state <= S_RESP;
                    end
                end
                S_SCAN: begin
                    if (w_due && w_better) begin
                        r_found    <= 1'b1;
                        r_best_idx <= r_scan_i;
                        r_best_dl  <= w_rd_dl;
                        r_best_age <= w_age;
                    end
                    if (r_scan_i == dtb_pkg::IDX_W'(dtb_pkg::NUM_SLOTS - 1)) begin
                        r_state <= S_PICK;
                    end else begin
                        r_scan_i <= r_scan_i + 1'b1;
                    end
                end
                S_PICK: begin
                    r_scan_i <= '0;
                    r_found  <= 1'b0;
                    if (r_found && (int'(r_n) < dtb_pkg::MAX_REP)) begin
                        r_active[r_best_idx] <= 1'b0;
                        r_res   <= mk_res(dtb_pkg::KIND_EXPIRE, 4'(r_best_idx),
                                          r_pass_fast, 1'b0, 32'd0, 1'b0);
                        r_n     <= r_n + 1'b1;
                        r_after <= S_SCAN;
                        r_state <= S_RESP;
                    end else if (r_pass_fast && r_gate) begin
                        r_pass_fast <= 1'b0;
                        r_state     <= S_SCAN;
                    end else begin
                        r_res   <= mk_res(dtb_pkg::KIND_DONE, 4'd0,
                                          1'b0, 1'b0, 32'd0, 1'b1);
                        r_after <= S_IDLE;
                        r_state <= S_RESP;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= r_res;
                        r_state     <= r_after;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ tb/deadline_timer_bank_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_timer_bank_checker: result predictor and scoreboard
// Watches both channels of the timer bank, keeps a shadow copy of every slot
// and of the tick rate, works out the results of each accepted command and
// compares every accepted result with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module deadline_timer_bank_checker
    import dtb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_item   i_in_item,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_item  i_out_item,
    input  logic       i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_report_count
);

    logic [31:0] tick_rate;
    logic        slot_on   [NUM_SLOTS];
    logic        slot_quick[NUM_SLOTS];
    logic [63:0] slot_due  [NUM_SLOTS];
    logic [31:0] slot_seq  [NUM_SLOTS];
    logic [31:0] arm_seq;
    logic [63:0] slow_check_time;
    t_out_item   expected_results[$];

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] rate64();
        return (tick_rate == 0) ? 64'd1 : {32'd0, tick_rate};
    endfunction

    function automatic t_out_item make_result(logic [1:0] k, logic [3:0] s, logic f,
                                              logic st, logic [31:0] r, logic l);
        t_out_item o;
        o.kind = k; o.slot = s; o.was_fast = f; o.status = st;
        o.remaining_seconds = r; o.last = l;
        return o;
    endfunction

    function automatic int earliest_due(logic [63:0] now, logic quick);
        int best;
        best = -1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!slot_on[i] || slot_quick[i] != quick || slot_due[i] > now) continue;
            if (best < 0 || slot_due[i] < slot_due[best] ||
                (slot_due[i] == slot_due[best] &&
                 (arm_seq - slot_seq[i]) > (arm_seq - slot_seq[best])))
                best = i;
        end
        return best;
    endfunction

    task automatic arm_slot(int id, logic [63:0] due, logic quick);
        slot_on[id] = 1'b1;
        slot_quick[id] = quick;
        slot_due[id] = due;
        slot_seq[id] = arm_seq;
        arm_seq++;
    endtask

    task automatic predict_command(t_in_item c);
        logic [63:0] mag;
        logic [63:0] rem;
        logic        gate;
        logic        on;
        int          n;
        int          s;
        mag = c.amount[31] ? 64'd0 : {32'd0, c.amount};
        on = slot_on[c.timer_id];
        case (c.action)
            ACT_POLL: begin
                n = 0;
                gate = (c.now - slow_check_time > rate64()) || slow_check_time == 0 ||
                       slow_check_time > c.now;
                if (gate) slow_check_time = c.now;
                for (int p = 0; p < 2; p++) begin
                    if (p == 1 && !gate) break;
                    while (n < MAX_REP) begin
                        s = earliest_due(c.now, p == 0);
                        if (s < 0) break;
                        slot_on[s] = 1'b0;
                        expected_results.push_back(make_result(KIND_EXPIRE, 4'(s), p == 0,
                                                               0, 0, 0));
                        n++;
                    end
                end
                expected_results.push_back(make_result(KIND_DONE, 0, 0, 0, 0, 1));
            end
            ACT_START_S: begin
                arm_slot(c.timer_id, add_sat(c.now, mag * rate64()), 1'b0);
                expected_results.push_back(make_result(KIND_ACK, c.timer_id, 0, 0, 0, 1));
            end
            ACT_START_F: begin
                arm_slot(c.timer_id, add_sat(c.now, mag), 1'b1);
                expected_results.push_back(make_result(KIND_ACK, c.timer_id, 0, 0, 0, 1));
            end
            ACT_STOP: begin
                slot_on[c.timer_id] = 1'b0;
                expected_results.push_back(make_result(KIND_ACK, c.timer_id, 0, !on, 0, 1));
            end
            ACT_DELAY: begin
                if (on)
                    arm_slot(c.timer_id, add_sat(slot_due[c.timer_id], mag * rate64()),
                             slot_quick[c.timer_id]);
                expected_results.push_back(make_result(KIND_ACK, c.timer_id, 0, !on, 0, 1));
            end
            ACT_REMAIN: begin
                rem = 0;
                if (on && slot_due[c.timer_id] > c.now)
                    rem = (slot_due[c.timer_id] - c.now) / rate64();
                if (rem > 64'hFFFF_FFFF) rem = 64'hFFFF_FFFF;
                expected_results.push_back(make_result(KIND_REMAIN, c.timer_id, 0, !on,
                                                       rem[31:0], 1));
            end
            default:
                expected_results.push_back(make_result(KIND_ACK, c.timer_id, 0, 1, 0, 1));
        endcase
    endtask

    task automatic compare_result(t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d slot %0d", got.kind, got.slot);
            o_fail_count++;
            return;
        end
        want = expected_results.pop_front();
        if (got.kind != want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind); o_fail_count++;
        end
        if (got.slot != want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, got.slot); o_fail_count++;
        end
        if (got.was_fast != want.was_fast) begin
            $error("was_fast: expected %0d, got %0d", want.was_fast, got.was_fast);
            o_fail_count++;
        end
        if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            o_fail_count++;
        end
        if (got.remaining_seconds != want.remaining_seconds) begin
            $error("remaining_seconds: expected %0d, got %0d",
                   want.remaining_seconds, got.remaining_seconds);
            o_fail_count++;
        end
        if (got.last != want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last); o_fail_count++;
        end
        if (got.kind == KIND_EXPIRE) o_report_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_report_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_rate = TPS_RESET;
            arm_seq = 0;
            slow_check_time = 0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_on[i] = 1'b0;
                slot_quick[i] = 1'b0;
            end
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) tick_rate = i_cfg_wr_data;
            if (i_in_valid && !i_in_stall) predict_command(i_in_item);
            if (i_out_valid && !i_out_stall) compare_result(i_out_item);
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/deadline_timer_bank_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deadline_timer_bank_tb: stimulus and verdict for the deadline timer bank
// Directed commands cover every action, clamping, saturation, stale slots
// and report limits; random phases then mix arming, delays, queries and
// polls under several tick rates and three idling patterns.
// ----------------------------------------------------------------------------
module deadline_timer_bank_tb;
    import dtb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_in_item    in_item;
    logic        out_valid;
    logic        out_stall;
    t_out_item   out_item;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    int          fail_count;
    int          pending;
    int          report_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          idle_cycles;
    int          sent_count;
    logic [63:0] clock_us;

    deadline_timer_bank dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data)
    );

    deadline_timer_bank_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_report_count(report_count)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_command(logic [2:0] act, logic [3:0] id, logic [31:0] amt,
                                logic [63:0] now);
        while ($urandom_range(99) < send_idle_pct) @(posedge clk);
        in_valid <= 1'b1;
        in_item <= '{action: act, timer_id: id, amount: amt, now: now};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        sent_count++;
    endtask

    task automatic write_rate(logic [31:0] rate);
        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= rate;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase(int count);
        int          pick;
        logic [2:0]  act;
        logic [31:0] amt;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 3) clock_us = {$urandom, $urandom};
            else if (pick < 8) clock_us = clock_us - $urandom_range(3000000);
            else clock_us = clock_us + $urandom_range(1500000);
            pick = $urandom_range(99);
            if (pick < 22) act = ACT_START_S;
            else if (pick < 40) act = ACT_START_F;
            else if (pick < 50) act = ACT_STOP;
            else if (pick < 60) act = ACT_DELAY;
            else if (pick < 70) act = ACT_REMAIN;
            else if (pick < 96) act = ACT_POLL;
            else act = 3'($urandom_range(7, 6));
            pick = $urandom_range(99);
            if (pick < 10) amt = $urandom;
            else if (pick < 20) amt = -$urandom_range(5);
            else if (act == ACT_START_F) amt = $urandom_range(3000000);
            else amt = $urandom_range(4);
            send_command(act, 4'($urandom_range(15)), amt, clock_us);
        end
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        idle_cycles = 0;
        sent_count = 0;
        send_idle_pct = 28;
        recv_idle_pct = 63;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every action, clamps, saturation, inactive slots, ties.
        send_command(ACT_REMAIN, 4'd3, 32'd0, 64'd0);
        send_command(ACT_STOP, 4'd3, 32'd0, 64'd0);
        send_command(ACT_DELAY, 4'd3, 32'd5, 64'd0);
        send_command(3'd6, 4'd0, 32'd0, 64'd0);
        send_command(3'd7, 4'd15, 32'hFFFF_FFFF, 64'd0);
        send_command(ACT_START_S, 4'd0, 32'h8000_0000, 64'd100);
        send_command(ACT_START_S, 4'd1, 32'h7FFF_FFFF, '1);
        send_command(ACT_START_F, 4'd2, -32'sd7, 64'd100);
        send_command(ACT_START_F, 4'd15, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00);
        send_command(ACT_START_S, 4'd4, 32'd3, 64'd100);
        send_command(ACT_DELAY, 4'd4, -32'sd2, 64'd100);
        send_command(ACT_DELAY, 4'd0, 32'd1, 64'd100);
        send_command(ACT_REMAIN, 4'd4, 32'd0, 64'd100);
        send_command(ACT_REMAIN, 4'd1, 32'd0, 64'd0);
        send_command(ACT_REMAIN, 4'd2, 32'd0, 64'd500);
        send_command(ACT_POLL, 4'd9, 32'd0, 64'd100);
        send_command(ACT_POLL, 4'd0, 32'd0, 64'd200);
        send_command(ACT_STOP, 4'd4, 32'd0, 64'd200);
        for (int i = 0; i < NUM_SLOTS; i++)
            send_command(i[0] ? ACT_START_F : ACT_START_S, 4'(i), 32'd0, 64'd1000);
        send_command(ACT_POLL, 4'd0, 32'd0, 64'd50);
        send_command(ACT_POLL, 4'd0, 32'd0, '1);

        write_rate(32'd0);
        clock_us = 64'd5000;
        random_phase(30);
        write_rate(32'hFFFF_FFFF);
        send_idle_pct = 63;
        recv_idle_pct = 28;
        random_phase(30);
        write_rate(32'd1);
        random_phase(25);
        write_rate(32'd1000000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(30);

        while (pending != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        $display("Sent %0d commands over four tick rates; %0d expiry reports checked.",
                 sent_count, report_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
